// ----- rtl/joint_trajectory_limiter_core_assert.svh -----
// Assertion macros used by the trajectory limiter controller.
`ifndef JOINT_TRAJECTORY_LIMITER_CORE_ASSERT_SVH
`define JOINT_TRAJECTORY_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JTL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define JTL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- rtl/jtl_pkg.sv -----
// Shared types and codes of the joint trajectory limiter.
`default_nettype none
package jtl_pkg;

  localparam logic [1:0] OP_STEP = 2'd0;
  localparam logic [1:0] OP_SEED = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam int DIV_W = 49;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic prep;
    logic div_start;
    logic lim;
    logic clmp;
    logic mul;
    logic fin;
    logic push;
  } jtl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step;
    logic div_done;
    logic out_free;
  } jtl_sts_t;

  // Clamp: minimum tested first, then maximum, so the maximum wins.
  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [31:0] t;
    t = (v < lo) ? lo : v;
    return (t > hi) ? hi : t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/jtl_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module jtl_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [jtl_pkg::DIV_W-1:0]   dividend,
  input  wire logic [15:0]                 divisor,
  output logic                             done,
  output logic [jtl_pkg::DIV_W-1:0]        quotient
);
  import jtl_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [16:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [16:0]   trial;

  // Shift one dividend bit into the remainder and subtract when it fits.
  always_comb begin
    trial    = {rem_r[15:0], q_r[DIV_W-1]};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DIV_W);
      rem_nxt  = '0;
      q_nxt    = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = busy_r && (cnt_r == CW'(1));
  assign quotient = q_r;

endmodule
`default_nettype wire

// ----- rtl/jtl_dp.sv -----
// Datapath: joint tables, limit arithmetic, divider and result register.
`default_nettype none
module jtl_dp #(
  parameter int JOINTS    = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire jtl_pkg::jtl_cmd_t   cmd,
  output jtl_pkg::jtl_sts_t        sts,
  input  wire logic                cfg_we,
  input  wire logic [3:0]          cfg_data,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [2:0]          in_joint,
  input  wire logic signed [31:0]  in_goal_q,
  input  wire logic                in_goal_valid,
  input  wire logic signed [31:0]  in_measured_q,
  input  wire logic [15:0]         in_dt,
  input  wire logic signed [31:0]  in_tau_ff,
  input  wire logic                in_tau_valid,
  input  wire logic signed [31:0]  in_lim_q_min,
  input  wire logic signed [31:0]  in_lim_q_max,
  input  wire logic [30:0]         in_lim_dq,
  input  wire logic [30:0]         in_lim_ddq,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic                     out_status,
  output logic signed [31:0]       out_ref_q,
  output logic signed [31:0]       out_ref_dq,
  output logic signed [31:0]       out_ref_tau,
  output logic                     out_ref_tau_valid
);
  import jtl_pkg::*;

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [4:0]  JN = 5'(JOINTS);
  localparam logic [63:0] PI_Q =
    (64'd13493037705 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic signed [31:0] PI_RST  = PI_Q[31:0];
  localparam logic [30:0]        VL_RST  = 31'(64'd1 << FRAC_BITS);
  localparam logic [30:0]        AL_RST  = 31'(64'd4 << FRAC_BITS);

  // Tables, one entry per joint.
  logic signed [31:0] goal_tab_r [JOINTS];
  logic signed [31:0] pos_tab_r  [JOINTS];
  logic signed [31:0] vel_tab_r  [JOINTS];
  logic [JOINTS-1:0]  seeded_r;
  logic signed [31:0] min_tab_r  [JOINTS];
  logic signed [31:0] max_tab_r  [JOINTS];
  logic [30:0]        vl_tab_r   [JOINTS];
  logic [30:0]        al_tab_r   [JOINTS];

  logic [3:0] jcount_r;

  // Latched item.
  logic [1:0]         op_r;
  logic [2:0]         j_r;
  logic signed [31:0] goal_in_r, meas_r, tau_r, lmin_r, lmax_r;
  logic               goal_valid_r, tau_valid_r;
  logic [15:0]        dt_r;
  logic [30:0]        ldq_r, lddq_r;

  // Working registers.
  logic signed [31:0] goal_r, pos_r, prev_r, des_r, ndq_r;
  logic signed [32:0] err_r, step_r;
  logic [30:0]        delta_r;

  // Result registers.
  logic               res_st_r, res_tv_r;
  logic signed [31:0] res_q_r, res_dq_r, res_tau_r;
  logic               out_valid_r;
  logic               out_st_r, out_tv_r;
  logic signed [31:0] out_q_r, out_dq_r, out_tau_r;

  logic [4:0]         j5, cnt_eff;
  logic [JW-1:0]      jix;
  logic               in_range, seeded_s;
  logic signed [31:0] mn, mx, cm, goal_src, goal_c, pos0, prev0;
  logic [30:0]        dql, ddql;
  logic signed [32:0] err_now;
  logic [32:0]        err_now_abs;
  logic [32:0]        err_abs;
  logic               div_done;
  logic [DIV_W-1:0]   quo;
  logic [31:0]        mag;
  logic signed [32:0] des_s;
  logic signed [31:0] des_c;
  logic [46:0]        acc_prod;
  logic signed [33:0] lo_v, hi_v, nd_t, nd_u, dql_s;
  logic signed [48:0] vprod;
  logic signed [33:0] nq_w, nq_s, step_abs, err_abs_s, mn_w, mx_w;
  logic               snap;
  logic signed [31:0] nq_c;

  // Decode the joint and its table entries.
  always_comb begin
    j5          = {2'b00, j_r};
    jix         = j5[JW-1:0];
    cnt_eff     = ({1'b0, jcount_r} > JN) ? JN : {1'b0, jcount_r};
    in_range    = (j5 < cnt_eff);
    seeded_s    = seeded_r[jix];
    mn          = min_tab_r[jix];
    mx          = max_tab_r[jix];
    dql         = vl_tab_r[jix];
    ddql        = al_tab_r[jix];
    cm          = clamp32(meas_r, mn, mx);
    pos0        = seeded_s ? pos_tab_r[jix] : cm;
    prev0       = seeded_s ? vel_tab_r[jix] : '0;
    goal_src    = goal_valid_r ? goal_in_r : (seeded_s ? goal_tab_r[jix] : cm);
    goal_c      = clamp32(goal_src, mn, mx);
    err_now     = 33'(goal_c) - 33'(pos0);
    err_now_abs = err_now[32] ? 33'(-err_now) : 33'(err_now);
    err_abs     = err_r[32] ? 33'(-err_r) : 33'(err_r);
  end

  // Saturate the quotient, then apply the velocity limit.
  always_comb begin
    if (err_r[32]) begin
      mag = (quo > DIV_W'(64'h8000_0000)) ? 32'h8000_0000 : quo[31:0];
    end else begin
      mag = (quo > DIV_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
    end
    des_s = err_r[32] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (dt_r == 16'd0) begin
      des_s = '0;
    end
    des_c = des_s[31:0];
    if (dql != 31'd0) begin
      des_c = clamp32(des_c, -$signed({1'b0, dql}), $signed({1'b0, dql}));
    end
    acc_prod = ddql * dt_r;
  end

  // Limit the velocity around the previous one and by the velocity limit.
  always_comb begin
    lo_v  = 34'(prev_r) - $signed({3'b000, delta_r});
    hi_v  = 34'(prev_r) + $signed({3'b000, delta_r});
    dql_s = $signed({3'b000, dql});
    nd_t  = 34'(des_r);
    if (ddql != 31'd0 && dt_r != 16'd0) begin
      nd_t = (nd_t < lo_v) ? lo_v : nd_t;
      nd_t = (nd_t > hi_v) ? hi_v : nd_t;
    end
    nd_u = nd_t;
    if (dql != 31'd0) begin
      nd_u = (nd_u < -dql_s) ? -dql_s : nd_u;
      nd_u = (nd_u > dql_s) ? dql_s : nd_u;
    end
    vprod = 49'(ndq_r) * $signed({33'd0, dt_r});
  end

  // Integrate, snap on overshoot, clamp into the position limits.
  always_comb begin
    nq_w      = 34'(pos_r) + 34'(step_r);
    step_abs  = step_r[32] ? -34'(step_r) : 34'(step_r);
    err_abs_s = $signed({1'b0, err_abs});
    snap      = (dt_r == 16'd0) || (step_abs >= err_abs_s);
    nq_s      = snap ? 34'(goal_r) : nq_w;
    mn_w      = 34'(mn);
    mx_w      = 34'(mx);
    nq_s      = (nq_s < mn_w) ? mn_w : nq_s;
    nq_s      = (nq_s > mx_w) ? mx_w : nq_s;
    nq_c      = nq_s[31:0];
  end

  jtl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({err_now_abs, 16'd0}),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (quo)
  );

  // Hold the latched item and the working values.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r         <= in_opcode;
      j_r          <= in_joint;
      goal_in_r    <= in_goal_q;
      goal_valid_r <= in_goal_valid;
      meas_r       <= in_measured_q;
      dt_r         <= in_dt;
      tau_r        <= in_tau_ff;
      tau_valid_r  <= in_tau_valid;
      lmin_r       <= in_lim_q_min;
      lmax_r       <= in_lim_q_max;
      ldq_r        <= in_lim_dq;
      lddq_r       <= in_lim_ddq;
    end
    if (cmd.prep) begin
      goal_r   <= goal_c;
      pos_r    <= pos0;
      prev_r   <= prev0;
      err_r    <= err_now;
      res_st_r <= !in_range;
      res_tau_r <= '0;
      res_tv_r <= 1'b0;
      if (in_range && op_r == OP_SEED) begin
        res_q_r  <= cm;
        res_dq_r <= '0;
      end else if (in_range && op_r != OP_STEP) begin
        res_q_r  <= pos_tab_r[jix];
        res_dq_r <= vel_tab_r[jix];
      end else begin
        res_q_r  <= '0;
        res_dq_r <= '0;
      end
    end
    if (cmd.lim) begin
      des_r   <= des_c;
      delta_r <= acc_prod[46:16];
    end
    if (cmd.clmp) begin
      ndq_r <= nd_u[31:0];
    end
    if (cmd.mul) begin
      step_r <= vprod[48:16];
    end
    if (cmd.fin) begin
      res_q_r   <= nq_c;
      res_dq_r  <= snap ? 32'sd0 : ndq_r;
      res_tau_r <= tau_valid_r ? tau_r : 32'sd0;
      res_tv_r  <= tau_valid_r;
    end
  end

  // Update the joint tables.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= '0;
      jcount_r <= 4'd8;
      for (int i = 0; i < JOINTS; i++) begin
        goal_tab_r[i] <= '0;
        pos_tab_r[i]  <= '0;
        vel_tab_r[i]  <= '0;
        min_tab_r[i]  <= -PI_RST;
        max_tab_r[i]  <= PI_RST;
        vl_tab_r[i]   <= VL_RST;
        al_tab_r[i]   <= AL_RST;
      end
    end else begin
      if (cfg_we) begin
        jcount_r <= cfg_data;
      end
      if (cmd.prep && in_range && op_r == OP_SEED) begin
        goal_tab_r[jix] <= cm;
        pos_tab_r[jix]  <= cm;
        vel_tab_r[jix]  <= '0;
        seeded_r[jix]   <= 1'b1;
      end
      if (cmd.prep && in_range && op_r == OP_LOAD) begin
        min_tab_r[jix] <= lmin_r;
        max_tab_r[jix] <= lmax_r;
        vl_tab_r[jix]  <= ldq_r;
        al_tab_r[jix]  <= lddq_r;
      end
      if (cmd.fin) begin
        goal_tab_r[jix] <= goal_r;
        pos_tab_r[jix]  <= nq_c;
        vel_tab_r[jix]  <= snap ? 32'sd0 : ndq_r;
        seeded_r[jix]   <= 1'b1;
      end
    end
  end

  // Output register: load on push, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.push) begin
      out_st_r  <= res_st_r;
      out_q_r   <= res_q_r;
      out_dq_r  <= res_dq_r;
      out_tau_r <= res_tau_r;
      out_tv_r  <= res_tv_r;
    end
  end

  assign sts.step     = in_range && (op_r == OP_STEP);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_status        = out_st_r;
  assign out_ref_q         = out_q_r;
  assign out_ref_dq        = out_dq_r;
  assign out_ref_tau       = out_tau_r;
  assign out_ref_tau_valid = out_tv_r;

endmodule
`default_nettype wire

// ----- rtl/jtl_ctrl.sv -----
// Controller state machine sequencing one item through the datapath.
`default_nettype none
`include "joint_trajectory_limiter_core_assert.svh"
module jtl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire jtl_pkg::jtl_sts_t  sts,
  output jtl_pkg::jtl_cmd_t       cmd
);
  import jtl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_LIM  = 3'd3;
  localparam logic [2:0] S_CLMP = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Advance through the step sequence; other opcodes and out-of-range joints go straight to output.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.step) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_LIM;
        end
      end
      S_LIM: begin
        cmd.lim   = 1'b1;
        state_nxt = S_CLMP;
      end
      S_CLMP: begin
        cmd.clmp  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  `JTL_ASSERT_IMP(a_done_in_div, sts.div_done, state_r == S_DIV)
  `JTL_ASSERT_IMP(a_push_free, cmd.push, sts.out_free)
  `JTL_ASSERT_NXT(a_latch_prep, cmd.latch, state_r == S_PREP && !in_ready)

endmodule
`default_nettype wire

// ----- rtl/joint_trajectory_limiter_core.sv -----
// Top level of the joint trajectory limiter.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | opcode, joint, goal, dt, torque, limits
//  out_    | output    | out_valid / out_ready | status, ref_q, ref_dq, ref_tau, flag
//  cfg_    | input     | cfg_we                | cfg_data (joint count)
//
// A step runs the bit-serial divider for error over dt, then the limit,
// clamp, multiply and write-back stages. Seed, limit load, unknown-opcode
// and out-of-range items skip them and go from prep straight to output.
// Reset is synchronous on rst_n low and restores all joint tables at once.
// The next item is taken once the result sits in the output register;
// a stalled output holds the controller before it pushes a new result.
`default_nettype none
module joint_trajectory_limiter_core #(
  parameter int JOINTS    = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [2:0]         in_joint,
  input  wire logic signed [31:0] in_goal_q,
  input  wire logic               in_goal_valid,
  input  wire logic signed [31:0] in_measured_q,
  input  wire logic [15:0]        in_dt,
  input  wire logic signed [31:0] in_tau_ff,
  input  wire logic               in_tau_valid,
  input  wire logic signed [31:0] in_lim_q_min,
  input  wire logic signed [31:0] in_lim_q_max,
  input  wire logic [30:0]        in_lim_dq,
  input  wire logic [30:0]        in_lim_ddq,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_status,
  output logic signed [31:0]      out_ref_q,
  output logic signed [31:0]      out_ref_dq,
  output logic signed [31:0]      out_ref_tau,
  output logic                    out_ref_tau_valid
);
  import jtl_pkg::*;

  jtl_cmd_t cmd;
  jtl_sts_t sts;

  jtl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jtl_dp #(
    .JOINTS    (JOINTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_opcode         (in_opcode),
    .in_joint          (in_joint),
    .in_goal_q         (in_goal_q),
    .in_goal_valid     (in_goal_valid),
    .in_measured_q     (in_measured_q),
    .in_dt             (in_dt),
    .in_tau_ff         (in_tau_ff),
    .in_tau_valid      (in_tau_valid),
    .in_lim_q_min      (in_lim_q_min),
    .in_lim_q_max      (in_lim_q_max),
    .in_lim_dq         (in_lim_dq),
    .in_lim_ddq        (in_lim_ddq),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_ref_q         (out_ref_q),
    .out_ref_dq        (out_ref_dq),
    .out_ref_tau       (out_ref_tau),
    .out_ref_tau_valid (out_ref_tau_valid)
  );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the joint trajectory limiter core.
`default_nettype none
module tb_top;
  import jtl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJ = 8;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         joint;
    logic signed [31:0] goal_q;
    logic               goal_valid;
    logic signed [31:0] measured_q;
    logic [15:0]        dt;
    logic signed [31:0] tau_ff;
    logic               tau_valid;
    logic signed [31:0] lim_q_min;
    logic signed [31:0] lim_q_max;
    logic [30:0]        lim_dq;
    logic [30:0]        lim_ddq;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] ref_q;
    logic signed [31:0] ref_dq;
    logic signed [31:0] ref_tau;
    logic               ref_tau_valid;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  cmd_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  setpoint_t got;

  joint_trajectory_limiter_core DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(cur.opcode), .in_joint(cur.joint), .in_goal_q(cur.goal_q),
    .in_goal_valid(cur.goal_valid), .in_measured_q(cur.measured_q), .in_dt(cur.dt),
    .in_tau_ff(cur.tau_ff), .in_tau_valid(cur.tau_valid),
    .in_lim_q_min(cur.lim_q_min), .in_lim_q_max(cur.lim_q_max),
    .in_lim_dq(cur.lim_dq), .in_lim_ddq(cur.lim_ddq),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(got.status), .out_ref_q(got.ref_q), .out_ref_dq(got.ref_dq),
    .out_ref_tau(got.ref_tau), .out_ref_tau_valid(got.ref_tau_valid)
  );

  always #1 clk = ~clk;

  // Predictor state
  logic [3:0]         pm_count;
  logic signed [31:0] pm_goal[NJ], pm_pos[NJ], pm_vel[NJ];
  logic               pm_seeded[NJ];
  logic signed [31:0] pm_qmin[NJ], pm_qmax[NJ], pm_vlim[NJ], pm_alim[NJ];

  cmd_t      pending_cmds[$];
  setpoint_t expected_setpoints[$];
  int        in_idle_pct = 0, out_stall_pct = 0;
  int        mismatches = 0, cycles = 0;

  function automatic longint clamp64(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic seed_joint(int j, logic signed [31:0] q);
    logic signed [31:0] c;
    c = 32'(clamp64(q, pm_qmin[j], pm_qmax[j]));
    pm_goal[j] = c;
    pm_pos[j] = c;
    pm_vel[j] = 0;
    pm_seeded[j] = 1'b1;
  endtask

  // Compute the setpoint an item yields and advance joint state
  task automatic plan_setpoint(input cmd_t c, output setpoint_t r);
    int j;
    longint qmin, qmax, dql, ddql, goal, pos, err, des, ndq, nq, delta;
    longint unsigned mag;
    j = c.joint;
    r = '0;
    if (j >= ((pm_count < NJ) ? pm_count : NJ)) begin
      r.status = 1'b1;
    end else if (c.opcode == OP_SEED) begin
      seed_joint(j, c.measured_q);
      r.ref_q = pm_pos[j];
    end else if (c.opcode == OP_STEP) begin
      if (!pm_seeded[j]) seed_joint(j, c.measured_q);
      qmin = pm_qmin[j];
      qmax = pm_qmax[j];
      dql = pm_vlim[j] > 0 ? pm_vlim[j] : 0;
      ddql = pm_alim[j] > 0 ? pm_alim[j] : 0;
      goal = c.goal_valid ? longint'(c.goal_q) : longint'(pm_goal[j]);
      goal = clamp64(goal, qmin, qmax);
      pm_goal[j] = 32'(goal);
      pos = pm_pos[j];
      err = goal - pos;
      des = 0;
      if (c.dt > 0) begin
        mag = longint'(abs64(err)) << 16;
        mag = mag / c.dt;
        des = err < 0 ? -longint'(mag) : longint'(mag);
        des = clamp64(des, -64'sd2147483648, 64'sd2147483647);
      end
      if (dql > 0) des = clamp64(des, -dql, dql);
      ndq = des;
      if (ddql > 0 && c.dt > 0) begin
        delta = (ddql * c.dt) >>> 16;
        ndq = clamp64(ndq, pm_vel[j] - delta, pm_vel[j] + delta);
      end
      if (dql > 0) ndq = clamp64(ndq, -dql, dql);
      nq = pos + ((ndq * longint'(c.dt)) >>> 16);
      if (c.dt == 0 || abs64(nq - pos) >= abs64(err)) begin
        nq = goal;
        ndq = 0;
      end
      nq = clamp64(nq, qmin, qmax);
      pm_pos[j] = 32'(nq);
      pm_vel[j] = 32'(ndq);
      r.ref_q = 32'(nq);
      r.ref_dq = 32'(ndq);
      r.ref_tau = c.tau_valid ? c.tau_ff : 32'sd0;
      r.ref_tau_valid = c.tau_valid;
    end else begin
      if (c.opcode == OP_LOAD) begin
        pm_qmin[j] = c.lim_q_min;
        pm_qmax[j] = c.lim_q_max;
        pm_vlim[j] = {1'b0, c.lim_dq};
        pm_alim[j] = {1'b0, c.lim_ddq};
      end
      r.ref_q = pm_pos[j];
      r.ref_dq = pm_vel[j];
    end
  endtask

  // Driver: present queued items, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        cur <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on acceptance
  always @(posedge clk) begin
    setpoint_t e;
    if (rst_n && in_valid && in_ready) begin
      plan_setpoint(cur, e);
      expected_setpoints.push_back(e);
    end
  end

  // Monitor: compare each result, randomize backpressure
  always @(posedge clk) begin
    setpoint_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_setpoints.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        e = expected_setpoints.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d q=%0d dq=%0d tau=%0d tv=%0d",
                      " | got st=%0d q=%0d dq=%0d tau=%0d tv=%0d"},
                     e.status, e.ref_q, e.ref_dq, e.ref_tau, e.ref_tau_valid,
                     got.status, got.ref_q, got.ref_dq, got.ref_tau, got.ref_tau_valid);
        end
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(600000)) - 300000;
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'hffff;
      default: return 16'($urandom_range(1, 700));
    endcase
  endfunction

  function automatic logic [30:0] rand_lim();
    case ($urandom_range(4))
      0: return 31'd0;
      1: return 31'($urandom);
      2: return 31'h7fffffff;
      default: return 31'($urandom_range(1, 600000));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int p;
    c.opcode = 2'($urandom_range(3));
    p = $urandom_range(99);
    if (p < 70) c.opcode = OP_STEP;
    else if (p < 80) c.opcode = OP_SEED;
    else if (p < 95) c.opcode = OP_LOAD;
    c.joint = 3'($urandom);
    c.goal_q = rand_pos();
    c.goal_valid = $urandom_range(3) != 0;
    c.measured_q = rand_pos();
    c.dt = rand_dt();
    c.tau_ff = $urandom;
    c.tau_valid = 1'($urandom_range(1));
    c.lim_q_min = $signed($urandom_range(400000)) - 420000;
    c.lim_q_max = $signed($urandom_range(400000)) + 20000;
    if ($urandom_range(9) == 0) begin
      c.lim_q_min = rand_pos();
      c.lim_q_max = rand_pos();
    end
    c.lim_dq = rand_lim();
    c.lim_ddq = rand_lim();
    return c;
  endfunction

  // Let all queued items drain, then wait out any trailing work
  task automatic drain();
    wait (pending_cmds.size() == 0 && !in_valid && expected_setpoints.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_count(logic [3:0] n);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= n;
    pm_count = n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    cmd_t c;
    int idle_sets[4][2] = '{'{0, 0}, '{53, 0}, '{0, 53}, '{20, 20}};
    logic [3:0] counts[4] = '{4'd8, 4'd1, 4'd15, 4'd0};
    pm_count = 8;
    for (int j = 0; j < NJ; j++) begin
      pm_goal[j] = 0; pm_pos[j] = 0; pm_vel[j] = 0; pm_seeded[j] = 0;
      pm_qmin[j] = -205887; pm_qmax[j] = 205887;
      pm_vlim[j] = 65536; pm_alim[j] = 262144;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unseeded step, extremes, every opcode, inverted limits
    c = '0; c.opcode = OP_STEP; c.joint = 0; c.measured_q = 32'sh7fffffff;
    c.goal_q = 32'sh80000000; c.goal_valid = 1; c.dt = 16'hffff;
    c.tau_ff = 32'sh80000000; c.tau_valid = 1;
    pending_cmds.push_back(c);
    c.dt = 0; pending_cmds.push_back(c);
    c.goal_valid = 0; c.dt = 1; pending_cmds.push_back(c);
    c.opcode = OP_SEED; c.joint = 1; c.measured_q = 32'sh80000000;
    pending_cmds.push_back(c);
    c.opcode = OP_LOAD; c.lim_q_min = 32'sh80000000; c.lim_q_max = 32'sh7fffffff;
    c.lim_dq = 0; c.lim_ddq = 0; pending_cmds.push_back(c);
    c.opcode = OP_STEP; c.goal_q = 32'sh7fffffff; c.goal_valid = 1; c.dt = 1;
    pending_cmds.push_back(c);
    c.dt = 16'hffff; pending_cmds.push_back(c);
    c.opcode = OP_LOAD; c.joint = 2; c.lim_q_min = 1000; c.lim_q_max = -1000;
    c.lim_dq = 31'h7fffffff; c.lim_ddq = 31'h7fffffff; pending_cmds.push_back(c);
    c.opcode = OP_STEP; c.goal_q = -5000; c.dt = 100; c.tau_valid = 0;
    pending_cmds.push_back(c);
    c.opcode = 2'd3; c.joint = 3; pending_cmds.push_back(c);
    c.opcode = OP_SEED; c.joint = 7; c.measured_q = 1234; pending_cmds.push_back(c);
    c.opcode = OP_STEP; c.goal_q = 1234; pending_cmds.push_back(c);
    c.lim_dq = 0; c.lim_ddq = 0; c.lim_q_min = 0; c.lim_q_max = 0;
    c.goal_q = 0; c.measured_q = 0; c.tau_ff = 0; pending_cmds.push_back(c);
    drain();

    // Random phases across joint counts and idle mixes
    for (int ph = 0; ph < 8; ph++) begin
      set_count(counts[ph % 4]);
      in_idle_pct = idle_sets[ph % 4][0];
      out_stall_pct = idle_sets[ph % 4][1];
      for (int i = 0; i < 230; i++) pending_cmds.push_back(rand_cmd());
      drain();
    end

    if (mismatches == 0 && expected_setpoints.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/jtl_pkg.sv
rtl/jtl_div.sv
rtl/jtl_dp.sv
rtl/jtl_ctrl.sv
rtl/joint_trajectory_limiter_core.sv
bench/tb_top.sv
